// ===== hdl/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

    // Data width of the input, output and configuration ports.
    localparam int unsigned PORT_WIDTH = 32;

    // One command word from the controller to the datapath per cycle.
    typedef struct packed {
        logic load;      // capture a new base and exponent
        logic red_step;  // one bit of the base reduction
        logic mul_init;  // clear the accumulators before a multiply pass
        logic mul_step;  // one multiplier bit of the multiply and square pass
        logic mul_end;   // commit the products of one exponent bit
        logic out_load;  // move the result into the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

// ===== hdl/modular_exponentiation.sv =====
// Modular exponentiation, power = base ** exponent mod modulus.
// The modulus is set through i_cfg_we / i_cfg_data and is 1 after reset;
// only its low OPERAND_WIDTH bits are used, and a zero modulus gives 0.
// It may be changed only while no word is in flight.
// Input words (i_base, i_exponent) are taken on i_in_valid & o_in_ready,
// result words (o_power) are delivered on o_out_valid & i_out_ready.
// One word is worked on at a time. The base is first reduced one bit
// at a time, then each exponent bit takes a bit-serial pass that forms
// result * base and base * base together, one multiplier bit per cycle,
// between a clear step and a commit step. The next word is accepted
// once the result has been moved into the output register.
// The result sits in an output register; if the receiver stalls, the
// block can take and compute the next word, but holds its result until
// the output register is free. A synchronous reset on i_rst_n drops any
// word in flight, clears o_out_valid and sets the modulus back to 1.
`default_nettype none

module modular_exponentiation import mexp_pkg::*; #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [PORT_WIDTH-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [PORT_WIDTH-1:0] i_base,
    input  wire logic [PORT_WIDTH-1:0] i_exponent,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic      [PORT_WIDTH-1:0] o_power
);

    t_dp_cmd cmd;

    mexp_ctrl #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    mexp_dp #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_base     (i_base),
        .i_exponent (i_exponent),
        .i_cmd      (cmd),
        .o_power    (o_power)
    );

endmodule

`default_nettype wire

// ===== hdl/mexp_dp.sv =====
`default_nettype none

module mexp_dp import mexp_pkg::*; #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [PORT_WIDTH-1:0] i_cfg_data,
    input  wire logic [PORT_WIDTH-1:0] i_base,
    input  wire logic [PORT_WIDTH-1:0] i_exponent,
    input  wire t_dp_cmd               i_cmd,
    output logic      [PORT_WIDTH-1:0] o_power
);

    localparam int unsigned W = OPERAND_WIDTH;

    // One step of an MSB-first interleaved modular multiply:
    // acc = (2 * acc + (add ? x : 0)) mod m, with acc and x below m.
    function automatic logic [W-1:0] f_modstep(
        input logic [W-1:0] acc,
        input logic         add,
        input logic [W-1:0] x,
        input logic [W-1:0] m
    );
        logic [W:0] t;
        logic [W:0] u;
        t = {acc, 1'b0};
        if (t >= {1'b0, m}) begin
            t = t - {1'b0, m};
        end
        u = t;
        if (add) begin
            u = t + {1'b0, x};
            if (u >= {1'b0, m}) begin
                u = u - {1'b0, m};
            end
        end
        return u[W-1:0];
    endfunction

    logic [PORT_WIDTH-1:0] r_mod;
    logic [W-1:0]          r_shift;
    logic [W-1:0]          r_b;
    logic [W-1:0]          r_e;
    logic [W-1:0]          r_r;
    logic [W-1:0]          r_acc_r;
    logic [W-1:0]          r_acc_b;
    logic                  r_zero_mod;
    logic [PORT_WIDTH-1:0] r_power;
    logic [W-1:0]          m;

    assign m = r_mod[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= PORT_WIDTH'(1);
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_shift    <= i_base[W-1:0];
            r_b        <= '0;
            r_e        <= i_exponent[W-1:0];
            r_r        <= (m == W'(1)) ? '0 : W'(1);
            r_zero_mod <= (m == '0);
        end
        // The base is reduced by shifting it in one bit at a time.
        if (i_cmd.red_step) begin
            r_b     <= f_modstep(r_b, r_shift[W-1], W'(1), m);
            r_shift <= {r_shift[W-2:0], 1'b0};
        end
        // Result times base and base squared share the bits of the base.
        if (i_cmd.mul_init) begin
            r_acc_r <= '0;
            r_acc_b <= '0;
            r_shift <= r_b;
        end
        if (i_cmd.mul_step) begin
            r_acc_r <= f_modstep(r_acc_r, r_shift[W-1], r_r, m);
            r_acc_b <= f_modstep(r_acc_b, r_shift[W-1], r_b, m);
            r_shift <= {r_shift[W-2:0], 1'b0};
        end
        if (i_cmd.mul_end) begin
            if (r_e[0]) begin
                r_r <= r_acc_r;
            end
            r_b <= r_acc_b;
            r_e <= {1'b0, r_e[W-1:1]};
        end
        if (i_cmd.out_load) begin
            r_power <= r_zero_mod ? '0 : PORT_WIDTH'(r_r);
        end
    end

    assign o_power = r_power;

endmodule

`default_nettype wire

// ===== hdl/mexp_ctrl.sv =====
`default_nettype none

module mexp_ctrl import mexp_pkg::*; #(
    parameter int unsigned OPERAND_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_dp_cmd   o_cmd
);

    localparam int unsigned CW = $clog2(OPERAND_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(OPERAND_WIDTH - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RED   = 3'd1;
    localparam logic [2:0] S_MINIT = 3'd2;
    localparam logic [2:0] S_MSTEP = 3'd3;
    localparam logic [2:0] S_MEND  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_bit, n_bit;
    logic [CW-1:0] r_ebit, n_ebit;
    logic          r_out_valid, n_out_valid;
    logic          accept;
    logic          out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_bit       = r_bit;
        n_ebit      = r_ebit;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_bit      = '0;
                    n_state    = S_RED;
                end
            end
            S_RED: begin
                o_cmd.red_step = 1'b1;
                n_bit          = r_bit + CW'(1);
                if (r_bit == LAST) begin
                    n_ebit  = '0;
                    n_state = S_MINIT;
                end
            end
            S_MINIT: begin
                o_cmd.mul_init = 1'b1;
                n_bit          = '0;
                n_state        = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.mul_step = 1'b1;
                n_bit          = r_bit + CW'(1);
                if (r_bit == LAST) begin
                    n_state = S_MEND;
                end
            end
            S_MEND: begin
                o_cmd.mul_end = 1'b1;
                n_ebit        = r_ebit + CW'(1);
                n_state       = (r_ebit == LAST) ? S_DONE : S_MINIT;
            end
            S_DONE: begin
                // Hold the finished word until the output register is free.
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_ebit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bit       <= n_bit;
            r_ebit      <= n_ebit;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire
